// ===== design/sce_pkg.sv =====
// Package for the scrambler and convolutional encoder.
// Holds the shared constants, register indexes and the configuration struct.
// No dependencies.
package sce_pkg;

  localparam int unsigned ScrWidth  = 17;
  localparam int unsigned HistWidth = 6;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [ScrWidth-1:0] ScrSeed = 17'h18E38;
  localparam int unsigned ScrTap = 14;

  typedef enum logic {
    REG_SCRAMBLE_EN = 1'b0,
    REG_CODING_EN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic scramble_en;
    logic coding_en;
  } sce_cfg_t;

endpackage

// ===== design/sce_in_if.sv =====
// Input channel interface: one frame byte and its frame start flag.
// Depends on sce_pkg for the byte width.
interface sce_in_if
  import sce_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] data_byte;
  logic                 frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== design/sce_out_if.sv =====
// Result channel interface: one coded word and its size flag.
// Depends on sce_pkg for the word width.
interface sce_out_if
  import sce_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [WordWidth-1:0] coded_word;
  logic                 word_is_two_bytes;

  modport source (output valid, output coded_word, output word_is_two_bytes, input ready);
  modport sink (input valid, input coded_word, input word_is_two_bytes, output ready);
endinterface

// ===== design/sce_cfg.sv =====
// APB-style configuration registers for scramble and coding enables.
// Depends on sce_pkg for register indexes and the configuration struct.
module sce_cfg
  import sce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output sce_cfg_t             cfg
);

  sce_cfg_t cfg_r;
  sce_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    unique case (idx)
      REG_SCRAMBLE_EN: begin
        prdata[0] = cfg_r.scramble_en;
        if (wr_en) begin
          cfg_nxt.scramble_en = pwdata[0];
        end
      end
      REG_CODING_EN: begin
        prdata[0] = cfg_r.coding_en;
        if (wr_en) begin
          cfg_nxt.coding_en = pwdata[0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{scramble_en: 1'b1, coding_en: 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/sce_scrambler.sv =====
// Additive 17-bit scrambler over one byte, MSB first, unrolled over eight bits.
// Depends on sce_pkg for widths, seed and feedback tap.
module sce_scrambler
  import sce_pkg::*;
(
  input  logic [ByteWidth-1:0] byte_in,
  input  logic                 frame_start,
  input  logic                 enable,
  input  logic [ScrWidth-1:0]  state_in,
  output logic [ByteWidth-1:0] byte_out,
  output logic [ScrWidth-1:0]  state_out
);

  logic [ScrWidth-1:0]  s;
  logic [ByteWidth-1:0] r;
  logic                 fb;

  always_comb begin
    s  = frame_start ? ScrSeed : state_in;
    r  = byte_in;
    fb = 1'b0;
    if (enable) begin
      for (int k = ByteWidth - 1; k >= 0; k--) begin
        fb   = s[0] ^ s[ScrTap];
        r[k] = byte_in[k] ^ s[0];
        s    = {fb, s[ScrWidth-1:1]};
      end
    end
    byte_out  = r;
    state_out = s;
  end

endmodule

// ===== design/sce_encoder.sv =====
// K=7 rate 1/2 convolutional encoder over one byte, MSB first, unrolled.
// Depends on sce_pkg for widths.
module sce_encoder
  import sce_pkg::*;
(
  input  logic [ByteWidth-1:0] byte_in,
  input  logic                 enable,
  input  logic [HistWidth-1:0] hist_in,
  output logic [WordWidth-1:0] word_out,
  output logic                 two_bytes,
  output logic [HistWidth-1:0] hist_out
);

  logic [HistWidth-1:0] h;
  logic [WordWidth-1:0] w;
  logic                 b;

  always_comb begin
    h = hist_in;
    w = {{(WordWidth-ByteWidth){1'b0}}, byte_in};
    b = 1'b0;
    if (enable) begin
      for (int k = ByteWidth - 1; k >= 0; k--) begin
        b          = byte_in[k];
        w[2*k+1]   = b ^ h[5] ^ h[4] ^ h[3] ^ h[0];
        w[2*k]     = ~(b ^ h[4] ^ h[3] ^ h[1] ^ h[0]);
        h          = {b, h[HistWidth-1:1]};
      end
    end
    word_out  = w;
    two_bytes = enable;
    hist_out  = h;
  end

endmodule

// ===== design/scrambler_and_conv_encoder.sv =====
// Scrambler and K=7 rate 1/2 convolutional encoder, top level.
// Uses sce_pkg, sce_in_if, sce_out_if, sce_cfg, sce_scrambler, sce_encoder.
//
// Usage:
//   in_ch carries one frame byte per transfer; frame_start reloads the
//   scrambler seed before that byte. out_ch returns exactly one result per
//   input byte: sixteen coded symbols big-endian, or the byte in bits 7..0
//   when coding is off (word_is_two_bytes tells which).
//   The APB port holds scramble enable (address 0) and coding enable
//   (address 4); write them only while the block is empty.
//   A byte accepted on in_ch waits in the input register, then moves to the
//   result register behind out_ch once it is free. Throughput: one byte per cycle
//   while out_ch takes results, set by the eight-bit XOR unroll between the two.
//   Reset: both enables on, scrambler at seed 0x18E38, encoder history zero,
//   both stages empty.
//   Stall: when out_ch is not taken the result holds; the input register
//   still takes one more byte, then in_ch.ready drops until out_ch moves.
module scrambler_and_conv_encoder
  import sce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sce_in_if.sink               in_ch,
  sce_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  sce_cfg_t cfg;

  logic                 in_valid_r;
  logic [ByteWidth-1:0] in_byte_r;
  logic                 in_fs_r;
  logic                 out_valid_r;
  logic [WordWidth-1:0] out_word_r;
  logic                 out_two_r;
  logic [ScrWidth-1:0]  scr_r;
  logic [ScrWidth-1:0]  scr_nxt;
  logic [HistWidth-1:0] hist_r;
  logic [HistWidth-1:0] hist_nxt;
  logic [ByteWidth-1:0] scr_byte;
  logic [WordWidth-1:0] word_nxt;
  logic                 two_nxt;
  logic                 out_free;
  logic                 adv;
  logic                 in_xfer;

  sce_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sce_scrambler u_scr (
    .byte_in     (in_byte_r),
    .frame_start (in_fs_r),
    .enable      (cfg.scramble_en),
    .state_in    (scr_r),
    .byte_out    (scr_byte),
    .state_out   (scr_nxt)
  );

  sce_encoder u_enc (
    .byte_in   (scr_byte),
    .enable    (cfg.coding_en),
    .hist_in   (hist_r),
    .word_out  (word_nxt),
    .two_bytes (two_nxt),
    .hist_out  (hist_nxt)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scr_r       <= ScrSeed;
      hist_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (adv) begin
        scr_r  <= scr_nxt;
        hist_r <= hist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_ch.data_byte;
      in_fs_r   <= in_ch.frame_start;
    end
    if (adv) begin
      out_word_r <= word_nxt;
      out_two_r  <= two_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.coded_word        = out_word_r;
  assign out_ch.word_is_two_bytes = out_two_r;

  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r))
    else $error("input stalled while a stage is empty");

  a_byte_mode_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_two_r) |-> (out_word_r[WordWidth-1:ByteWidth] == '0))
    else $error("uncoded result has nonzero upper byte");

  a_seed_reload_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_fs_r && !cfg.scramble_en) |=> (scr_r == ScrSeed))
    else $error("seed not reloaded with scrambling off");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg.coding_en) |=> $stable(hist_r))
    else $error("encoder history moved with coding off");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for scrambler_and_conv_encoder: directed table plus random frames,
// each result checked against a bit-level predictor of scrambler and K=7 encoder, or a directed row's word.
// Depends on sce_pkg, sce_in_if, sce_out_if and the design sources.
`timescale 1ns / 1ps

module tb_top;
  import sce_pkg::*;

  localparam int TotalItems    = 1050;
  localparam int WatchdogLimit = 1000;
  localparam int NumDir        = 21;

  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 two;
  } coded_t;

  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 fs;
    logic                 scr_en;
    logic                 cod_en;
    logic                 known;
    logic [WordWidth-1:0] word;
    logic                 two;
  } dir_row_t;

  dir_row_t dir_rows [NumDir] = '{
    '{8'h1C, 1'b1, 1'b1, 1'b1, 1'b1, 16'h5555, 1'b1},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hA5, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 16'h00FF, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0080, 1'b0},
    '{8'h01, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0001, 1'b0},
    // reload the seed while scrambling is off, then use it unadvanced
    '{8'h55, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0055, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 16'h001C, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 16'h00E3, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h01, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hC3, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'h3C, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  sce_in_if  in_ch ();
  sce_out_if out_ch ();

  scrambler_and_conv_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state, at reset values
  logic                 scramble_on = 1'b1;
  logic                 coding_on   = 1'b1;
  logic [ScrWidth-1:0]  lfsr_state  = ScrSeed;
  logic [HistWidth-1:0] enc_history = '0;

  coded_t expected_words [$];
  int     items_sent    = 0;
  int     words_coded   = 0;
  int     words_plain   = 0;
  int     config_phases = 0;
  int     mismatches    = 0;
  int     idle_cycles   = 0;
  int     sink_hold     = 0;
  logic   src_quiet     = 1'b0;
  logic   sink_quiet    = 1'b0;

  always #2 clk = ~clk;

  function automatic int draw_gap(input logic quiet);
    return quiet ? 0 : int'($urandom_range(0, 14));
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (mismatches < 10)
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    mismatches++;
  endfunction

  function automatic logic [AddrWidth-1:0] reg_addr(input reg_idx_t idx);
    return AddrWidth'({idx, 2'b00});
  endfunction

  // advance scrambler and encoder state by one byte
  function automatic coded_t encode_byte(input logic [ByteWidth-1:0] din, input logic fs);
    logic [ByteWidth-1:0] b;
    logic [ScrWidth-1:0]  s;
    logic [HistWidth-1:0] h;
    logic                 fb;
    logic                 bit_in;
    coded_t               res;
    b   = din;
    res = '0;
    if (fs)
      lfsr_state = ScrSeed;
    if (scramble_on) begin
      s = lfsr_state;
      for (int k = 7; k >= 0; k--) begin
        b[k] = b[k] ^ s[0];
        fb   = s[0] ^ s[ScrTap];
        s    = {fb, s[ScrWidth-1:1]};
      end
      lfsr_state = s;
    end
    if (coding_on) begin
      h = enc_history;
      for (int k = 7; k >= 0; k--) begin
        bit_in           = b[k];
        res.word[2*k+1]  = bit_in ^ h[5] ^ h[4] ^ h[3] ^ h[0];
        res.word[2*k]    = ~(bit_in ^ h[4] ^ h[3] ^ h[1] ^ h[0]);
        h                = {bit_in, h[HistWidth-1:1]};
      end
      enc_history = h;
      res.two     = 1'b1;
    end else begin
      res.word = {8'h00, b};
      res.two  = 1'b0;
    end
    return res;
  endfunction

  task automatic send_byte(input logic [ByteWidth-1:0] d, input logic fs, input logic fixed,
                           input coded_t fixed_res);
    int     gap;
    coded_t res;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.frame_start <= fs;
    do @(posedge clk); while (!in_ch.ready);
    res = encode_byte(d, fs);
    expected_words.push_back(fixed ? fixed_res : res);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic apb_transfer(input reg_idx_t idx, input logic wr,
                              input logic [DataWidth-1:0] wdata,
                              output logic [DataWidth-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= reg_addr(idx);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      if (idx == REG_SCRAMBLE_EN) scramble_on = wdata[0];
      else coding_on = wdata[0];
    end
  endtask

  task automatic check_reg(input reg_idx_t idx);
    logic [DataWidth-1:0] rd;
    logic [DataWidth-1:0] want;
    apb_transfer(idx, 1'b0, '0, rd);
    want = DataWidth'(idx == REG_SCRAMBLE_EN ? scramble_on : coding_on);
    if (rd !== want)
      note_mismatch(idx == REG_SCRAMBLE_EN ? "scramble_enable read" : "coding_enable read",
                    want, rd);
  endtask

  task automatic set_config(input logic s_en, input logic c_en);
    logic [DataWidth-1:0] rd;
    wait_drained();
    apb_transfer(REG_SCRAMBLE_EN, 1'b1, DataWidth'(s_en), rd);
    apb_transfer(REG_CODING_EN, 1'b1, DataWidth'(c_en), rd);
    check_reg(REG_SCRAMBLE_EN);
    check_reg(REG_CODING_EN);
    psel    <= 1'b0;
    penable <= 1'b0;
    config_phases++;
  endtask

  always @(posedge clk) begin : result_check
    coded_t want;
    if (!rst_n) begin
      sink_hold = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.word_is_two_bytes) words_coded++;
        else words_plain++;
        if (expected_words.size() == 0) begin
          note_mismatch("result with nothing expected", 32'h0,
                        {15'h0, out_ch.coded_word, out_ch.word_is_two_bytes});
        end else begin
          want = expected_words.pop_front();
          if (out_ch.coded_word !== want.word)
            note_mismatch("coded_word", 32'(want.word), 32'(out_ch.coded_word));
          if (out_ch.word_is_two_bytes !== want.two)
            note_mismatch("word_is_two_bytes", 32'(want.two), 32'(out_ch.word_is_two_bytes));
        end
        sink_hold = draw_gap(sink_quiet);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_ch.ready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [ByteWidth-1:0] d;
    logic                 fs;
    logic                 broken;
    int                   flen;
    int                   phase_end;
    int                   combo;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    check_reg(REG_SCRAMBLE_EN);
    check_reg(REG_CODING_EN);
    psel    <= 1'b0;
    penable <= 1'b0;

    for (int i = 0; i < NumDir; i++) begin
      if (dir_rows[i].scr_en !== scramble_on || dir_rows[i].cod_en !== coding_on)
        set_config(dir_rows[i].scr_en, dir_rows[i].cod_en);
      send_byte(dir_rows[i].data, dir_rows[i].fs, dir_rows[i].known,
                coded_t'{dir_rows[i].word, dir_rows[i].two});
    end

    combo = 0;
    while (items_sent < TotalItems) begin
      // walk all four settings first, then pick at random
      if (combo >= 4) combo = $urandom_range(0, 3);
      set_config(combo[1], combo[0]);
      combo++;
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      phase_end  = items_sent + $urandom_range(80, 160);
      while (items_sent < phase_end && items_sent < TotalItems) begin
        flen   = $urandom_range(1, 40);
        broken = ($urandom_range(0, 9) == 0);
        for (int j = 0; j < flen; j++) begin
          case ($urandom_range(0, 7))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            default: d = 8'($urandom);
          endcase
          fs = broken ? 1'($urandom_range(0, 1)) : (j == 0);
          send_byte(d, fs, 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes over %0d register settings, framed and unframed, with random stalls",
             items_sent, config_phases);
    $display("Got %0d coded words and %0d plain bytes, %0d mismatches",
             words_coded, words_plain, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sce_pkg.sv
design/sce_in_if.sv
design/sce_out_if.sv
design/sce_cfg.sv
design/sce_scrambler.sv
design/sce_encoder.sv
design/scrambler_and_conv_encoder.sv
bench/tb_top.sv
